// ===== hdl/ile_pkg.sv =====
// Shared types, sizes and codes for the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 16;
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== hdl/ile_ram.sv =====
// Element store: one write port and one registered read port.
`timescale 1ns / 1ps

module ile_ram
    import ile_pkg::*;
(
    input  logic             i_clk,
    input  t_ram_req         i_req,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ile_seq.sv =====
// Command decode, shift sequencer and result register of the list engine.
`timescale 1ns / 1ps

module ile_seq
    import ile_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [STAT_W-1:0]     m_axis_tuser,
    output t_ram_req              o_ram_req,
    input  logic [VAL_W-1:0]      i_ram_rdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        r_state,     n_state;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic              r_rd_act,    n_rd_act;
    logic              r_pend,      n_pend;
    logic [ADDR_W-1:0] r_rd_addr,   n_rd_addr;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic [ADDR_W-1:0] r_lim,       n_lim;
    logic              r_ins,       n_ins;
    logic [VAL_W-1:0]  r_val,       n_val;
    logic [VAL_W-1:0]  r_res_value, n_res_value;
    logic [STAT_W-1:0] r_res_stat,  n_res_stat;
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_out_value, n_out_value;
    logic [STAT_W-1:0] r_out_stat,  n_out_stat;
    logic [CNT_W-1:0]  r_out_count, n_out_count;

    logic [POS_W-1:0]  w_pos;
    logic [VAL_W-1:0]  w_value;
    logic [ADDR_W-1:0] w_pos_addr;
    logic [CMP_W-1:0]  w_pos_c;
    logic [CMP_W-1:0]  w_cnt_c;
    logic              w_pos_ok;
    logic              w_full;
    logic              w_ins_go;
    logic [ADDR_W-1:0] w_ins_pos;
    logic              w_out_free;

    assign w_pos      = s_axis_tdata[POS_W-1:0];
    assign w_value    = s_axis_tdata[POS_W+VAL_W-1:POS_W];
    assign w_pos_addr = w_pos[ADDR_W-1:0];
    assign w_pos_c    = CMP_W'(w_pos);
    assign w_cnt_c    = CMP_W'(r_count);
    assign w_pos_ok   = !w_pos[POS_W-1] && (w_pos_c < w_cnt_c);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-VAL_W-CNT_W){1'b0}}, r_out_count, r_out_value};
    assign m_axis_tuser  = r_out_stat;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_act    = r_rd_act;
        n_pend      = r_pend;
        n_rd_addr   = r_rd_addr;
        n_pend_addr = r_pend_addr;
        n_lim       = r_lim;
        n_ins       = r_ins;
        n_val       = r_val;
        n_res_value = r_res_value;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_stat  = r_out_stat;
        n_out_count = r_out_count;
        o_ram_req   = '0;
        w_ins_go    = 1'b0;
        w_ins_pos   = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_res_value = '0;
                    n_res_stat  = STAT_RANGE;
                    n_state     = ST_DONE;
                    unique case (s_axis_tuser)
                        CMD_READ: begin
                            if (w_pos_ok) begin
                                o_ram_req.re    = 1'b1;
                                o_ram_req.raddr = w_pos_addr;
                                n_res_stat      = STAT_OK;
                                n_state         = ST_READ;
                            end else begin
                                n_res_value = '1;
                            end
                        end
                        CMD_INS_HEAD: begin
                            w_ins_go = 1'b1;
                        end
                        CMD_INS_TAIL: begin
                            w_ins_go  = 1'b1;
                            w_ins_pos = r_count[ADDR_W-1:0];
                        end
                        CMD_INS_AT: begin
                            priority if (w_pos[POS_W-1] || (w_pos == '0)) begin
                                w_ins_go = 1'b1;
                            end else if (w_pos_c <= w_cnt_c) begin
                                w_ins_go  = 1'b1;
                                w_ins_pos = w_pos_addr;
                            end
                        end
                        CMD_DELETE: begin
                            if (w_pos_ok) begin
                                n_res_stat = STAT_OK;
                                if (CNT_W'(w_pos_addr) == r_count - CNT_W'(1)) begin
                                    n_count = r_count - CNT_W'(1);
                                end else begin
                                    // walk up, moving each element one place down
                                    n_rd_act  = 1'b1;
                                    n_pend    = 1'b0;
                                    n_rd_addr = w_pos_addr + ADDR_W'(1);
                                    n_lim     = ADDR_W'(r_count - CNT_W'(1));
                                    n_ins     = 1'b0;
                                    n_state   = ST_SHIFT;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (w_ins_go) begin
                        if (w_full) begin
                            n_res_stat = STAT_FULL;
                        end else if (w_ins_pos == r_count[ADDR_W-1:0]) begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = w_ins_pos;
                            o_ram_req.wdata = w_value;
                            n_count         = r_count + CNT_W'(1);
                            n_res_stat      = STAT_OK;
                        end else begin
                            // walk down from the tail, moving each element one place up
                            n_rd_act   = 1'b1;
                            n_pend     = 1'b0;
                            n_rd_addr  = r_count[ADDR_W-1:0] - ADDR_W'(1);
                            n_lim      = w_ins_pos;
                            n_ins      = 1'b1;
                            n_val      = w_value;
                            n_res_stat = STAT_OK;
                            n_state    = ST_SHIFT;
                        end
                    end
                end
            end
            ST_READ: begin
                n_res_value = i_ram_rdata;
                n_state     = ST_DONE;
            end
            ST_SHIFT: begin
                if (r_rd_act) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_rd_addr;
                    n_pend_addr     = r_ins ? (r_rd_addr + ADDR_W'(1))
                                            : (r_rd_addr - ADDR_W'(1));
                    if (r_rd_addr == r_lim) begin
                        n_rd_act = 1'b0;
                    end else begin
                        n_rd_addr = r_ins ? (r_rd_addr - ADDR_W'(1))
                                          : (r_rd_addr + ADDR_W'(1));
                    end
                end
                n_pend = r_rd_act;
                if (r_pend) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_pend_addr;
                    o_ram_req.wdata = i_ram_rdata;
                end
                if (!r_rd_act && !r_pend) begin
                    if (r_ins) begin
                        o_ram_req.we    = 1'b1;
                        o_ram_req.waddr = r_lim;
                        o_ram_req.wdata = r_val;
                        n_count         = r_count + CNT_W'(1);
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res_value;
                    n_out_stat  = r_res_stat;
                    n_out_count = r_count;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_act    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_act    <= n_rd_act;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_pend_addr <= n_pend_addr;
        r_lim       <= n_lim;
        r_ins       <= n_ins;
        r_val       <= n_val;
        r_res_value <= n_res_value;
        r_res_stat  <= n_res_stat;
        r_out_value <= n_out_value;
        r_out_stat  <= n_out_stat;
        r_out_count <= n_out_count;
    end

endmodule

// ===== hdl/indexed_list_engine_unit.sv =====
// Top level of the indexed list engine: an ordered store of signed 32-bit words.
//
// Commands arrive on the s_axis channel: tuser carries the command code, tdata
// the position and the value. Each command yields one word on the m_axis
// channel: tdata carries the read value and the element count after the
// command, tuser the status (done, out of range, store full).
// One command is worked at a time. A read passes through the READ and DONE
// states before its value is loaded into the output register; a command that
// only checks or touches one entry goes straight to DONE. An insert before
// position p moves count-p elements and a delete at p moves count-p-1
// elements, one element per cycle through the read and write ports of the
// element store, in the SHIFT state. The next command can be accepted in the
// cycle after the result is loaded. The output register lets the next command
// be accepted and worked while a result waits; a stalled receiver only stops
// the engine once a second result is finished. Reset empties the list (count
// zero) at once with no clearing pass; store entries are only read after they
// have been written.
`timescale 1ns / 1ps

module indexed_list_engine_unit
    import ile_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // position[15:0], value[47:16]
    input  logic [CMD_W-1:0]      s_axis_tuser,   // command[2:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // read_value[31:0], count[42:32], zeros
    output logic [STAT_W-1:0]     m_axis_tuser    // status[1:0]
);

    t_ram_req         w_ram_req;
    logic [VAL_W-1:0] w_ram_rdata;

    ile_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_ram_req     (w_ram_req),
        .i_ram_rdata   (w_ram_rdata)
    );

    ile_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

`ifndef ASSERT_OFF
    a_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_req.we && w_ram_req.re) |-> (w_ram_req.waddr != w_ram_req.raddr))
        else $error("store read and write hit the same entry");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_RANGE ||
                           m_axis_tuser == STAT_FULL))
        else $error("undefined status code");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[VAL_W+CNT_W-1:VAL_W] <= CNT_W'(CAPACITY)))
        else $error("count above capacity");

    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STAT_FULL) |->
            (m_axis_tdata[VAL_W+CNT_W-1:VAL_W] == CNT_W'(CAPACITY)))
        else $error("store full reported below capacity");
`endif

endmodule
